@@ sv/erc_pkg.sv @@
// Package: constants, phase codes and register indexes of the rep counter.
package erc_pkg;
    localparam int ADVANCE_TRIGGER_DEF     = 1229;
    localparam int REP_COMPLETE_DEF        = 614;
    localparam int MAX_PLAUSIBLE_ANGLE_DEF = 11520;
    localparam int TIME_WIDTH_DEF          = 32;

    localparam int ANGLE_W = 14;
    localparam int CFG_W   = 16;
    localparam int IDX_W   = 3;

    localparam logic [13:0] LEAN_OFF = 14'd11520;

    localparam logic [2:0] PH_IDLE      = 3'd0;
    localparam logic [2:0] PH_ALIGNING  = 3'd1;
    localparam logic [2:0] PH_READY     = 3'd2;
    localparam logic [2:0] PH_ADVANCING = 3'd3;
    localparam logic [2:0] PH_PEAK      = 3'd4;
    localparam logic [2:0] PH_RETURNING = 3'd5;

    localparam logic [IDX_W-1:0] REG_START    = 3'd0;
    localparam logic [IDX_W-1:0] REG_TARGET   = 3'd1;
    localparam logic [IDX_W-1:0] REG_DEPTH    = 3'd2;
    localparam logic [IDX_W-1:0] REG_LEAN     = 3'd3;
    localparam logic [IDX_W-1:0] REG_MIN_REP  = 3'd4;
    localparam logic [IDX_W-1:0] REG_MAX_REP  = 3'd5;
    localparam logic [IDX_W-1:0] REG_ALIGN    = 3'd6;
    localparam logic [IDX_W-1:0] REG_MIN_PLAU = 3'd7;

    typedef struct packed {
        logic start;
        logic mul;
    } mdu_cmd_t;
endpackage

@@ sv/erc_mdu.sv @@
// Shared serial unit: signed restoring divide or shift-add multiply, one bit per cycle.
module erc_mdu
    import erc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  mdu_cmd_t           cmd,
    input  logic signed [31:0] op_a,
    input  logic signed [15:0] op_b,
    output logic               done,
    output logic signed [31:0] result
);
    logic        busy_reg;
    logic [4:0]  cnt_reg;
    logic        mul_reg;
    logic        neg_reg;
    logic [31:0] a_reg;
    logic [15:0] b_reg;
    logic [31:0] q_reg;
    logic [31:0] r_reg;
    logic [32:0] trial;
    logic [31:0] rsh;
    logic [31:0] abs_a;
    logic [15:0] abs_b;

    assign abs_a = op_a[31] ? 32'(-op_a) : op_a;
    assign abs_b = op_b[15] ? 16'(-op_b) : op_b;
    assign rsh   = {r_reg[30:0], a_reg[31]};
    assign trial = {1'b0, rsh} - {17'd0, b_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
        end else begin
            done <= 1'b0;
            if (cmd.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'd31;
                mul_reg  <= cmd.mul;
                neg_reg  <= op_a[31] ^ op_b[15];
                a_reg    <= abs_a;
                b_reg    <= abs_b;
                q_reg    <= '0;
                r_reg    <= '0;
            end else if (busy_reg) begin
                if (mul_reg) begin
                    // a * b, b up to 16 bits: scan bits of b
                    if (b_reg[0]) q_reg <= q_reg + a_reg;
                    a_reg <= {a_reg[30:0], 1'b0};
                    b_reg <= {1'b0, b_reg[15:1]};
                end else begin
                    a_reg <= {a_reg[30:0], 1'b0};
                    if (!trial[32]) begin
                        r_reg <= trial[31:0];
                        q_reg <= {q_reg[30:0], 1'b1};
                    end else begin
                        r_reg <= rsh;
                        q_reg <= {q_reg[30:0], 1'b0};
                    end
                end
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd0) begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

    assign result = neg_reg ? 32'(-q_reg) : q_reg;
endmodule

@@ sv/exercise_rep_counter_unit.sv @@
// Top level: pose-frame rep counter with a phase machine over a shared serial unit.
// Usage:
//   s_axis_* carries one pose frame per transfer; m_axis_* returns one status result
//   per frame. cfg_we/cfg_idx/cfg_data write the eight setup registers; the user must
//   write them only while idle, which the block itself does not enforce.
// Sequencing:
//   A valid frame runs the serial divide for progress, then the step and output
//   sequencer states. A frame that closes a rep also runs the serial multiply of the
//   peak angle check. Invalid frames skip the divide. The single divide/multiply unit
//   limits the rate; one frame is in work at a time and s_axis_tready is low meanwhile.
// Reset:
//   aresetn (synchronous, active low) clears counts, phase and registers to defaults.
// Stall:
//   The result is held in an output register until m_axis_tready; the next frame is
//   taken at the earliest in the cycle after the result has been transferred.
module exercise_rep_counter_unit
    import erc_pkg::*;
#(
    parameter int ADVANCE_TRIGGER     = ADVANCE_TRIGGER_DEF,
    parameter int REP_COMPLETE        = REP_COMPLETE_DEF,
    parameter int MAX_PLAUSIBLE_ANGLE = MAX_PLAUSIBLE_ANGLE_DEF,
    parameter int TIME_WIDTH          = TIME_WIDTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // joint_angle[15:0], torso_lean[31:16], aligned[32], timestamp[64:33], pad
    input  logic [71:0]       s_axis_tdata,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // reps[15:0], fsm_state[18:16], violations[20:19],
    // progress_clamped[33:21], last_peak[49:34], pad
    output logic [55:0]       m_axis_tdata,
    input  logic              cfg_we,
    input  logic [IDX_W-1:0]  cfg_idx,
    input  logic [CFG_W-1:0]  cfg_data
);
    typedef enum logic [2:0] {S_IDLE, S_DIV, S_STEP, S_MUL, S_RESOLVE, S_OUT} seq_t;
    localparam logic signed [31:0] ADV = 32'(ADVANCE_TRIGGER);
    localparam logic signed [31:0] RC  = 32'(REP_COMPLETE);
    localparam logic signed [31:0] MPA = 32'(MAX_PLAUSIBLE_ANGLE);

    logic [13:0] start_reg, target_reg, lean_lim_reg, min_plau_reg;
    logic [12:0] depth_reg;
    logic [15:0] min_rep_reg, max_rep_reg, align_reg;

    seq_t        seq_reg;
    logic signed [15:0] joint_reg, lean_reg;
    logic        al_reg;
    logic [TIME_WIDTH-1:0] now_reg;
    logic        valid_reg;
    logic signed [15:0] prog_reg;

    logic [2:0]  phase_reg;
    logic [15:0] reps_reg;
    logic [1:0]  viol_reg;
    logic [TIME_WIDTH-1:0] att_start_reg, al_start_reg;
    logic        reached_reg, leaned_reg, await_reg, has_al_reg;
    logic signed [15:0] att_peak_reg, latched_reg, recent_reg;
    logic        out_valid_reg;
    logic [55:0] out_data_reg;

    mdu_cmd_t    cmd;
    logic signed [31:0] op_a, mdu_res;
    logic signed [15:0] op_b;
    logic        mdu_done;

    logic signed [15:0] span;
    logic [TIME_WIDTH-1:0] el_att, el_al;
    logic signed [31:0] q_sat_in;
    logic signed [15:0] q_sat;
    logic signed [31:0] angle;
    logic [12:0] shown;

    assign span   = 16'($signed({2'b0, target_reg})) - 16'($signed({2'b0, start_reg}));
    assign el_att = now_reg - att_start_reg;
    assign el_al  = now_reg - al_start_reg;
    assign q_sat_in = mdu_res;
    assign q_sat  = (q_sat_in > 32'sd32767) ? 16'sh7fff :
                    (q_sat_in < -32'sd32768) ? 16'sh8000 : q_sat_in[15:0];
    // C-style truncating /4096 of the product
    assign angle  = 32'($signed({18'd0, start_reg})) +
                    ((mdu_res < 0) ? -((-mdu_res) >>> 12) : (mdu_res >>> 12));

    erc_mdu u_mdu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .op_a    (op_a),
        .op_b    (op_b),
        .done    (mdu_done),
        .result  (mdu_res)
    );

    always_comb begin
        cmd  = '0;
        op_a = 32'($signed({joint_reg, 12'd0})) - 32'($signed({6'd0, start_reg, 12'd0}));
        op_b = span;
        if (seq_reg == S_IDLE && s_axis_tvalid && s_axis_tready) begin
            cmd.start = !s_axis_tdata[15] && start_reg != target_reg;
            op_a = 32'($signed({s_axis_tdata[15:0], 12'd0}))
                 - 32'($signed({6'd0, start_reg, 12'd0}));
        end
        if (seq_reg == S_STEP && phase_reg == PH_RETURNING && valid_reg && al_reg
            && !(el_att > TIME_WIDTH'(max_rep_reg)) && 32'(prog_reg) < RC) begin
            cmd.start = 1'b1;
            cmd.mul   = 1'b1;
            op_a      = 32'(att_peak_reg);
        end
    end

    assign s_axis_tready = (seq_reg == S_IDLE) && !out_valid_reg;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign shown = recent_reg < 0 ? 13'd0 : (recent_reg > 16'sd4096 ? 13'd4096
                                                                     : recent_reg[12:0]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg <= 14'd11520; target_reg <= 14'd5760; depth_reg <= 13'd3686;
            lean_lim_reg <= 14'd11520; min_rep_reg <= 16'd700; max_rep_reg <= 16'd6000;
            align_reg <= 16'd1000; min_plau_reg <= 14'd320;
            seq_reg <= S_IDLE; phase_reg <= PH_IDLE; reps_reg <= '0; viol_reg <= '0;
            att_start_reg <= '0; al_start_reg <= '0; reached_reg <= 1'b0;
            leaned_reg <= 1'b0; await_reg <= 1'b0; has_al_reg <= 1'b0;
            att_peak_reg <= '0; latched_reg <= '0; recent_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_idx)
                    REG_START:    start_reg    <= cfg_data[13:0];
                    REG_TARGET:   target_reg   <= cfg_data[13:0];
                    REG_DEPTH:    depth_reg    <= cfg_data[12:0];
                    REG_LEAN:     lean_lim_reg <= cfg_data[13:0];
                    REG_MIN_REP:  min_rep_reg  <= cfg_data;
                    REG_MAX_REP:  max_rep_reg  <= cfg_data;
                    REG_ALIGN:    align_reg    <= cfg_data;
                    REG_MIN_PLAU: min_plau_reg <= cfg_data[13:0];
                    default: ;
                endcase
            end
            if (out_valid_reg && m_axis_tready) out_valid_reg <= 1'b0;
            unique case (seq_reg)
                S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
                    joint_reg <= s_axis_tdata[15:0];
                    lean_reg  <= s_axis_tdata[31:16];
                    al_reg    <= s_axis_tdata[32];
                    now_reg   <= TIME_WIDTH'(s_axis_tdata[64:33]);
                    valid_reg <= !s_axis_tdata[15] && start_reg != target_reg;
                    seq_reg   <= (!s_axis_tdata[15] && start_reg != target_reg) ? S_DIV
                                                                               : S_STEP;
                end
                S_DIV: if (mdu_done) begin
                    prog_reg   <= q_sat;
                    recent_reg <= q_sat;
                    seq_reg    <= S_STEP;
                end
                S_STEP: begin
                    seq_reg <= S_OUT;
                    if (!al_reg) begin
                        if (phase_reg != PH_IDLE) phase_reg <= PH_ALIGNING;
                        has_al_reg <= 1'b0;
                    end else begin
                        if (!has_al_reg) begin
                            has_al_reg   <= 1'b1;
                            al_start_reg <= now_reg;
                        end
                        if ((phase_reg == PH_ADVANCING || phase_reg == PH_PEAK ||
                             phase_reg == PH_RETURNING) && el_att > TIME_WIDTH'(max_rep_reg)) begin
                            phase_reg <= PH_READY;
                            await_reg <= 1'b1;
                        end else begin
                            if (valid_reg && (phase_reg == PH_ADVANCING ||
                                phase_reg == PH_PEAK || phase_reg == PH_RETURNING)
                                && prog_reg > att_peak_reg)
                                att_peak_reg <= prog_reg;
                            if ((phase_reg == PH_ADVANCING || phase_reg == PH_PEAK ||
                                 phase_reg == PH_RETURNING) && !lean_reg[15]
                                && lean_lim_reg < LEAN_OFF
                                && lean_reg[14:0] > {1'b0, lean_lim_reg})
                                leaned_reg <= 1'b1;
                            case (phase_reg)
                                PH_IDLE: phase_reg <= PH_ALIGNING;
                                PH_ALIGNING:
                                    if ((has_al_reg ? el_al : '0) >= TIME_WIDTH'(align_reg))
                                        phase_reg <= PH_READY;
                                PH_READY:
                                    if (valid_reg && 32'(prog_reg) < RC)
                                        await_reg <= 1'b0;
                                    else if (valid_reg && !await_reg && 32'(prog_reg) > ADV) begin
                                        att_start_reg <= now_reg;
                                        reached_reg   <= 1'b0;
                                        leaned_reg    <= 1'b0;
                                        att_peak_reg  <= prog_reg;
                                        phase_reg     <= PH_ADVANCING;
                                    end
                                PH_ADVANCING:
                                    if (valid_reg && prog_reg > $signed({3'b0, depth_reg})) begin
                                        reached_reg <= 1'b1;
                                        phase_reg   <= PH_PEAK;
                                    end else if (valid_reg && 32'(prog_reg) < ADV)
                                        phase_reg <= PH_RETURNING;
                                PH_PEAK:
                                    if (valid_reg && 32'(prog_reg) < ADV)
                                        phase_reg <= PH_RETURNING;
                                PH_RETURNING:
                                    if (valid_reg && 32'(prog_reg) < RC)
                                        seq_reg <= S_MUL;
                                    else if (valid_reg && 32'(prog_reg) > ADV)
                                        phase_reg <= PH_ADVANCING;
                                default: ;
                            endcase
                        end
                    end
                end
                S_MUL: if (mdu_done) seq_reg <= S_RESOLVE;
                S_RESOLVE: begin
                    phase_reg <= PH_READY;
                    seq_reg   <= S_OUT;
                    if (!(!reached_reg && el_att < TIME_WIDTH'(min_rep_reg)) &&
                        !(angle < 32'($signed({18'd0, min_plau_reg})) || angle > MPA)) begin
                        if (reps_reg != 16'hffff) reps_reg <= reps_reg + 16'd1;
                        latched_reg <= att_peak_reg;
                        viol_reg    <= {leaned_reg, !reached_reg};
                    end
                end
                S_OUT: begin
                    out_valid_reg <= 1'b1;
                    out_data_reg  <= {6'd0, latched_reg, shown, viol_reg, phase_reg, reps_reg};
                    seq_reg       <= S_IDLE;
                end
                default: seq_reg <= S_IDLE;
            endcase
        end
    end
endmodule

@@ verif/exercise_rep_counter_unit_test.sv @@
// Testbench: random pose-frame streams through the rep counter, checked against a local predictor.
`timescale 1ns / 1ps

module exercise_rep_counter_unit_test;
    import erc_pkg::*;

    typedef struct {
        logic signed [15:0] joint;
        logic signed [15:0] lean;
        logic               al;
        logic [31:0]        ts;
    } frame_t;

    typedef struct {
        logic [15:0] reps;
        logic [2:0]  ph;
        logic [1:0]  viol;
        logic [12:0] prog;
        logic [15:0] peak;
    } status_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;
    logic        cfg_we = 1'b0;
    logic [IDX_W-1:0] cfg_idx = REG_START;
    logic [CFG_W-1:0] cfg_data = '0;

    exercise_rep_counter_unit u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
    );

    always #6 aclk = ~aclk;

    // register shadows
    int cs = 11520, ct = 5760, cdepth = 3686, clean = 11520;
    int cminrep = 700, cmaxrep = 6000, calign = 1000, cminpl = 320;

    // counter state
    logic [2:0]  phase = PH_IDLE;
    int          reps = 0;
    logic [1:0]  vbits = 2'b00;
    logic [31:0] attempt_start = '0;
    logic        reached = 1'b0;
    logic        leaned = 1'b0;
    int          attempt_peak = 0;
    int          latched_peak = 0;
    logic        awaiting = 1'b0;
    logic [31:0] aligned_start = '0;
    logic        has_aligned = 1'b0;
    int          recent = 0;

    frame_t  frame_q[$];
    status_t status_q[$];
    int      errors = 0;
    int      mismatches = 0;
    logic [31:0] ts_now = 32'd0;
    bit      long_hold_req = 0;

    function automatic longint unsigned span_ms(logic [31:0] now, logic [31:0] since);
        logic [31:0] d;
        d = now - since;
        return longint'(d);
    endfunction

    function automatic bit in_attempt();
        return phase == PH_ADVANCING || phase == PH_PEAK || phase == PH_RETURNING;
    endfunction

    task automatic note_lean(logic signed [15:0] lean);
        if (lean >= 0 && clean < 11520 && int'(lean) > clean) leaned = 1'b1;
    endtask

    task automatic close_rep(logic [31:0] now);
        longint angle;
        angle = longint'(cs) + (longint'(attempt_peak) * longint'(ct - cs)) / 4096;
        if (!reached && span_ms(now, attempt_start) < longint'(cminrep)) return;
        if (angle < cminpl || angle > MAX_PLAUSIBLE_ANGLE_DEF) return;
        if (reps < 65535) reps++;
        latched_peak = attempt_peak;
        vbits = {leaned, !reached};
    endtask

    task automatic count_frame(frame_t f, output status_t r);
        bit     valid;
        int     prog;
        longint q;
        int     shown;
        valid = f.joint >= 0 && cs != ct;
        prog = 0;
        if (valid) begin
            q = ((longint'(f.joint) - cs) * 4096) / longint'(ct - cs);
            if (q > 32767) q = 32767;
            if (q < -32768) q = -32768;
            prog = int'(q);
            recent = prog;
        end
        if (!f.al) begin
            if (phase != PH_IDLE) phase = PH_ALIGNING;
            has_aligned = 1'b0;
        end else begin
            if (!has_aligned) begin
                has_aligned = 1'b1;
                aligned_start = f.ts;
            end
            if (in_attempt() && span_ms(f.ts, attempt_start) > longint'(cmaxrep)) begin
                phase = PH_READY;
                awaiting = 1'b1;
            end else begin
                if (valid && in_attempt() && prog > attempt_peak) attempt_peak = prog;
                case (phase)
                    PH_IDLE: phase = PH_ALIGNING;
                    PH_ALIGNING: begin
                        if (span_ms(f.ts, aligned_start) >= longint'(calign)) phase = PH_READY;
                    end
                    PH_READY: begin
                        if (valid && prog < REP_COMPLETE_DEF) begin
                            awaiting = 1'b0;
                        end else if (valid && !awaiting && prog > ADVANCE_TRIGGER_DEF) begin
                            attempt_start = f.ts;
                            reached = 1'b0;
                            leaned = 1'b0;
                            attempt_peak = prog;
                            phase = PH_ADVANCING;
                        end
                    end
                    PH_ADVANCING: begin
                        note_lean(f.lean);
                        if (valid && prog > cdepth) begin
                            reached = 1'b1;
                            phase = PH_PEAK;
                        end else if (valid && prog < ADVANCE_TRIGGER_DEF) begin
                            phase = PH_RETURNING;
                        end
                    end
                    PH_PEAK: begin
                        note_lean(f.lean);
                        if (valid && prog < ADVANCE_TRIGGER_DEF) phase = PH_RETURNING;
                    end
                    PH_RETURNING: begin
                        note_lean(f.lean);
                        if (valid && prog < REP_COMPLETE_DEF) begin
                            close_rep(f.ts);
                            phase = PH_READY;
                        end else if (valid && prog > ADVANCE_TRIGGER_DEF) begin
                            phase = PH_ADVANCING;
                        end
                    end
                    default: ;
                endcase
            end
        end
        shown = recent < 0 ? 0 : (recent > 4096 ? 4096 : recent);
        r.reps = reps[15:0];
        r.ph   = phase;
        r.viol = vbits;
        r.prog = shown[12:0];
        r.peak = latched_peak[15:0];
    endtask

    // driver
    frame_t cur;
    bit     taken = 0;
    int     burst_left = 0;
    int     gap_left = 0;

    always @(posedge aclk) begin
        status_t r;
        taken <= aresetn && s_axis_tvalid && s_axis_tready;
        if (aresetn && s_axis_tvalid && s_axis_tready) begin
            count_frame(cur, r);
            status_q.push_back(r);
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || taken) begin
            if (gap_left > 0) begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end else if (frame_q.size() > 0) begin
                cur = frame_q.pop_front();
                s_axis_tdata <= {7'b0, cur.ts, cur.al, cur.lean, cur.joint};
                s_axis_tvalid <= 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 20);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 40);
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver
    int stall_left = 0;
    int rx_cycle = 0;
    int rx_mode = 0;
    bit long_hold_done = 0;

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else if (long_hold_req && !long_hold_done) begin
            long_hold_done = 1;
            stall_left = 600;
            m_axis_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else begin
            rx_cycle++;
            if (rx_cycle % 97 == 0) rx_mode = $urandom_range(0, 2);
            case (rx_mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= $urandom_range(0, 1);
                default: m_axis_tready <= ($urandom_range(0, 9) != 0);
            endcase
        end
    end

    // monitor
    always @(posedge aclk) begin
        status_t e, a;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            a.reps = m_axis_tdata[15:0];
            a.ph   = m_axis_tdata[18:16];
            a.viol = m_axis_tdata[20:19];
            a.prog = m_axis_tdata[33:21];
            a.peak = m_axis_tdata[49:34];
            if (status_q.size() == 0) begin
                errors++;
                mismatches++;
                if (mismatches <= 10) $display("unexpected transfer %h", m_axis_tdata);
            end else begin
                e = status_q.pop_front();
                if (a.reps !== e.reps || a.ph !== e.ph || a.viol !== e.viol ||
                    a.prog !== e.prog || a.peak !== e.peak) begin
                    errors++;
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp reps %0d ph %0d viol %0d prog %0d peak %0d",
                                  " | got reps %0d ph %0d viol %0d prog %0d peak %0d"},
                                 e.reps, e.ph, e.viol, e.prog, $signed(e.peak),
                                 a.reps, a.ph, a.viol, a.prog, $signed(a.peak));
                end
            end
        end
    end

    task automatic push_frame(int joint, int lean, bit al, int dt);
        frame_t f;
        ts_now = ts_now + dt;
        f.joint = joint[15:0];
        f.lean  = lean[15:0];
        f.al    = al;
        f.ts    = ts_now;
        frame_q.push_back(f);
    endtask

    function automatic int angle_at(int p);
        int j;
        if (cs == ct) return $urandom_range(0, 11520);
        j = cs + ((ct - cs) * p) / 4096;
        return j < 0 ? 0 : (j > 11520 ? 11520 : j);
    endfunction

    function automatic int any_lean();
        case ($urandom_range(0, 5))
            0: return -int'($urandom_range(1, 32768));
            1: return $urandom_range(0, 11520);
            default: return (clean < 11520 && $urandom_range(0, 3) == 0) ?
                            clean + $urandom_range(1, 50) : $urandom_range(0, clean);
        endcase
    endfunction

    task automatic push_noise();
        int j;
        case ($urandom_range(0, 4))
            0: j = -int'($urandom_range(1, 32768));
            default: j = $urandom_range(0, 11520);
        endcase
        case ($urandom_range(0, 5))
            0: ts_now = $urandom;
            1: ts_now = ts_now - $urandom_range(1, 5000);
            default: ;
        endcase
        push_frame(j, any_lean(), $urandom_range(0, 2) != 0, $urandom_range(0, 500));
    endtask

    task automatic push_rep();
        int k, pk, p, dt;
        dt = calign / 3 + 1;
        for (int i = 0; i < 4; i++) push_frame(angle_at(0), any_lean(), 1, dt);
        k = $urandom_range(2, 7);
        pk = $urandom_range(0, 4) == 0 ? $urandom_range(1300, 3000) : $urandom_range(2000, 4800);
        for (int i = 1; i <= k; i++) begin
            if ($urandom_range(0, 15) == 0) push_noise();
            p = (pk * i) / k;
            push_frame(angle_at(p), any_lean(), 1, $urandom_range(5, 400));
        end
        k = $urandom_range(2, 7);
        for (int i = k - 1; i >= 0; i--) begin
            if ($urandom_range(0, 15) == 0) push_noise();
            p = (pk * i) / k;
            push_frame(angle_at(p), any_lean(), 1, $urandom_range(5, 400));
        end
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, int val);
        @(negedge aclk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val[15:0];
        case (idx)
            REG_START:    cs = val;
            REG_TARGET:   ct = val;
            REG_DEPTH:    cdepth = val;
            REG_LEAN:     clean = val;
            REG_MIN_REP:  cminrep = val;
            REG_MAX_REP:  cmaxrep = val;
            REG_ALIGN:    calign = val;
            default:      cminpl = val;
        endcase
    endtask

    task automatic set_regs(int s, int t, int d, int l, int mn, int mx, int al, int mp);
        write_reg(REG_START, s);
        write_reg(REG_TARGET, t);
        write_reg(REG_DEPTH, d);
        write_reg(REG_LEAN, l);
        write_reg(REG_MIN_REP, mn);
        write_reg(REG_MAX_REP, mx);
        write_reg(REG_ALIGN, al);
        write_reg(REG_MIN_PLAU, mp);
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        do @(posedge aclk);
        while (frame_q.size() != 0 || s_axis_tvalid || status_q.size() != 0);
        repeat (100) @(posedge aclk);
    endtask

    initial begin
        int n;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        repeat (4) @(posedge aclk);
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: set_regs(11520, 5760, 3686, 11520, 700, 6000, 1000, 320);
                1: set_regs(0, 11520, 8191, 0, 0, 65535, 0, 0);
                2: set_regs(4000, 4000, 2000, 5000, 700, 6000, 100, 320);
                3: set_regs(2000, 9000, 3000, 3000, 65535, 3000, 200, 11520);
                4: set_regs(11520, 0, 0, 11520, 0, 0, 65535, 0);
                default: set_regs($urandom_range(0, 11520), $urandom_range(0, 11520),
                                  $urandom_range(0, 8191), $urandom_range(0, 11520),
                                  $urandom_range(0, 2000), $urandom_range(1000, 8000),
                                  $urandom_range(0, 2000), $urandom_range(0, 2000));
            endcase
            if (ph == 0) begin
                // field extremes, lost alignment, wrap and backwards time
                ts_now = 32'hFFFF_FF00;
                push_frame(0, 0, 0, 0);
                push_frame(-32768, -32768, 1, 0);
                push_frame(11520, 11520, 1, 300);
                push_frame(angle_at(0), 0, 1, 800);
                push_frame(angle_at(0), 0, 1, 300);
                push_frame(angle_at(3000), 11520, 1, 100);
                push_frame(angle_at(4096), 0, 1, 100);
                push_frame(-1, 0, 1, 100);
                push_frame(angle_at(2000), 0, 0, 100);
                push_frame(angle_at(0), 0, 1, 100);
                push_frame(angle_at(0), 0, 1, 1200);
                push_frame(angle_at(2000), 0, 1, 100);
                push_frame(angle_at(2000), 0, 1, 7000);
                push_frame(angle_at(0), 0, 1, 100);
                push_frame(angle_at(2000), 0, 1, 100);
                ts_now = 32'd0;
                push_frame(angle_at(2000), 0, 1, 0);
                ts_now = 32'hFFFF_FFFF;
                push_frame(angle_at(0), 0, 1, 0);
                push_frame(angle_at(4096), 0, 1, 100);
                push_frame(angle_at(0), 0, 1, 100);
            end
            n = frame_q.size();
            while (frame_q.size() - n < 120) begin
                if ($urandom_range(0, 7) == 0) push_noise();
                else push_rep();
            end
            if (ph == 3) begin
                repeat (50) @(posedge aclk);
                long_hold_req = 1;
            end
            wait_drained();
        end
        if (errors == 0 && status_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
